// ===== sv/ipufc_pkg.sv =====
// Shared types, codes and constants for the IPv4/UDP frame checker.
package ipufc_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 65535;
    localparam int unsigned COUNT_W         = 16;

    // Link type register codes
    localparam logic [2:0] LT_LOOPBACK = 3'd0;
    localparam logic [2:0] LT_ETHERNET = 3'd1;
    localparam logic [2:0] LT_SLIP     = 3'd2;
    localparam logic [2:0] LT_PPP      = 3'd3;

    // Status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_BAD_LINK   = 4'd1;
    localparam logic [3:0] ST_NOT_IPV4   = 4'd2;
    localparam logic [3:0] ST_SHORT      = 4'd3;
    localparam logic [3:0] ST_VERSION    = 4'd4;
    localparam logic [3:0] ST_HLEN       = 4'd5;
    localparam logic [3:0] ST_SHORT_HLEN = 4'd6;
    localparam logic [3:0] ST_CHECKSUM   = 4'd7;
    localparam logic [3:0] ST_NOT_UDP    = 4'd8;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  IP_VERSION     = 4'd4;
    localparam logic [5:0]  MIN_HDR_BYTES  = 6'd20;
    localparam logic [COUNT_W-1:0] MIN_IP_BYTES = COUNT_W'(28);
    localparam logic [6:0]  UDP_HDR_BYTES  = 7'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [3:0] status;
        logic [4:0] ip_start;
        logic [5:0] header_bytes;
    } out_beat_t;

    function automatic logic [4:0] link_len(input logic [2:0] lt);
        logic [4:0] len;
        case (lt)
            LT_LOOPBACK: len = 5'd4;
            LT_ETHERNET: len = 5'd14;
            LT_SLIP:     len = 5'd24;
            LT_PPP:      len = 5'd24;
            default:     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/ipufc_hdr_check.sv =====
// Per-frame header state and status decision for one byte beat.
module ipufc_hdr_check import ipufc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  in_beat_t  beat,
    input  logic [2:0] link_type,
    output out_beat_t result
);

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]        ether_kind_reg, ether_kind_next;
    logic [7:0]         version_ihl_reg, version_ihl_next;
    logic [7:0]         protocol_reg, protocol_next;
    logic [15:0]        sum_reg, sum_next;
    logic [7:0]         high_half_reg, high_half_next;

    logic [COUNT_W-1:0] pos, rel, count, ip_len;
    logic [15:0]        frame_ether, frame_sum;
    logic [7:0]         frame_vihl, frame_proto, frame_high;
    logic               supported;
    logic [4:0]         lhl;
    logic [5:0]         hdr_now, hdr;
    logic [16:0]        word_sum;
    logic [6:0]         hdr_plus_udp;
    logic [3:0]         status;

    always_comb begin
        pos       = byte_count_reg;
        supported = (link_type <= LT_PPP);
        lhl       = link_len(link_type);
        rel       = pos - COUNT_W'(lhl);
        hdr_now   = {((rel == '0) ? beat.data_byte[3:0] : version_ihl_reg[3:0]), 2'b00};
        word_sum  = {1'b0, sum_reg} + {1'b0, high_half_reg, beat.data_byte};

        count       = byte_count_reg;
        frame_ether = ether_kind_reg;
        frame_vihl  = version_ihl_reg;
        frame_proto = protocol_reg;
        frame_sum   = sum_reg;
        frame_high  = high_half_reg;

        // Hold everything once the counter has saturated
        if (pos != COUNT_W'(MAX_FRAME_BYTES)) begin
            if (pos == COUNT_W'(12)) begin
                frame_ether[15:8] = beat.data_byte;
            end else if (pos == COUNT_W'(13)) begin
                frame_ether[7:0] = beat.data_byte;
            end
            if (supported && (pos >= COUNT_W'(lhl))) begin
                if (rel == '0) begin
                    frame_vihl = beat.data_byte;
                end
                if (rel == COUNT_W'(9)) begin
                    frame_proto = beat.data_byte;
                end
                if (rel < COUNT_W'(hdr_now)) begin
                    if (!rel[0]) begin
                        frame_high = beat.data_byte;
                    end else begin
                        // end-around carry
                        frame_sum = word_sum[16] ? (word_sum[15:0] + 16'd1) : word_sum[15:0];
                    end
                end
            end
            count = pos + COUNT_W'(1);
        end

        ip_len       = count - COUNT_W'(lhl);
        hdr          = (count == COUNT_W'(lhl)) ? 6'd0 : {frame_vihl[3:0], 2'b00};
        hdr_plus_udp = {1'b0, hdr} + UDP_HDR_BYTES;

        if (!supported) begin
            status = ST_BAD_LINK;
        end else if (count < COUNT_W'(lhl)) begin
            status = ST_SHORT;
        end else if ((link_type == LT_ETHERNET) && (frame_ether != ETHERTYPE_IPV4)) begin
            status = ST_NOT_IPV4;
        end else if (ip_len < MIN_IP_BYTES) begin
            status = ST_SHORT;
        end else if (frame_vihl[7:4] != IP_VERSION) begin
            status = ST_VERSION;
        end else if (hdr < MIN_HDR_BYTES) begin
            status = ST_HLEN;
        end else if (ip_len < COUNT_W'(hdr_plus_udp)) begin
            status = ST_SHORT_HLEN;
        end else if (frame_sum != 16'hFFFF) begin
            status = ST_CHECKSUM;
        end else if (frame_proto != PROTO_UDP) begin
            status = ST_NOT_UDP;
        end else begin
            status = ST_OK;
        end

        result.status       = status;
        result.ip_start     = supported ? lhl : 5'd0;
        result.header_bytes = (supported && (count >= COUNT_W'(lhl))) ? hdr : 6'd0;

        // Clear frame state after the last beat
        if (beat.last_byte) begin
            byte_count_next  = '0;
            ether_kind_next  = '0;
            version_ihl_next = '0;
            protocol_next    = '0;
            sum_next         = '0;
            high_half_next   = '0;
        end else begin
            byte_count_next  = count;
            ether_kind_next  = frame_ether;
            version_ihl_next = frame_vihl;
            protocol_next    = frame_proto;
            sum_next         = frame_sum;
            high_half_next   = frame_high;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= '0;
            ether_kind_reg  <= '0;
            version_ihl_reg <= '0;
            protocol_reg    <= '0;
            sum_reg         <= '0;
            high_half_reg   <= '0;
        end else if (step_en) begin
            byte_count_reg  <= byte_count_next;
            ether_kind_reg  <= ether_kind_next;
            version_ihl_reg <= version_ihl_next;
            protocol_reg    <= protocol_next;
            sum_reg         <= sum_next;
            high_half_reg   <= high_half_next;
        end
    end

endmodule

// ===== sv/ipv4_udp_frame_check.sv =====
// Top level: input beat register, link type register, frame checker and result register.
// m_valid rises once the last byte has passed the input beat register and its result is registered.
// Throughput: one byte per cycle while no last byte waits on a stalled result.
// A last byte waits in the input register only while a previous result is stalled.
// Reset (aresetn low, synchronous) clears all frame state and sets link_type to Ethernet.
module ipv4_udp_frame_check import ipufc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [2:0] cfg_data
);

    logic [2:0] link_type_reg;
    logic       s1_valid_reg, s1_valid_next;
    in_beat_t   s1_beat_reg;
    logic       m_valid_reg, m_valid_next;
    out_beat_t  m_data_reg;
    out_beat_t  result;
    logic       advance;

    assign cfg_ready = 1'b1;

    // Non-final beats never need the result slot
    assign advance = s1_valid_reg && (!s1_beat_reg.last_byte || !m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_valid && s_ready) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance && s1_beat_reg.last_byte) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    ipufc_hdr_check u_hdr_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .beat      (s1_beat_reg),
        .link_type (link_type_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_type_reg <= LT_ETHERNET;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                link_type_reg <= cfg_data;
            end
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_beat_reg <= s_data;
        end
        if (advance && s1_beat_reg.last_byte) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_reset_link: assert property (@(posedge aclk)
        !aresetn |=> (link_type_reg == LT_ETHERNET))
        else $error("link type not Ethernet after reset");

    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_beat_reg.last_byte && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while last beat is stuck");

    a_ok_has_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status == ST_OK)) |->
        ((m_data_reg.ip_start != 5'd0) && (m_data_reg.header_bytes >= MIN_HDR_BYTES)))
        else $error("ok status with bad offsets");

    a_bad_link_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status == ST_BAD_LINK)) |->
        ((m_data_reg.ip_start == 5'd0) && (m_data_reg.header_bytes == 6'd0)))
        else $error("bad link status with nonzero fields");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the IPv4/UDP frame checker: byte-level predictor and scoreboard.
module tb_top;
    import ipufc_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_CYCLES = 300;

    typedef enum int {
        FK_GOOD, FK_BAD_CSUM, FK_VERSION, FK_HLEN, FK_SHORT_HLEN,
        FK_NOT_UDP, FK_ETHERTYPE, FK_TRUNC, FK_LINK_ONLY, FK_NOISE
    } frame_kind_e;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_beat_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_beat_t m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_data  = '0;

    ipv4_udp_frame_check u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    in_beat_t  frame_byte_q[$];
    out_beat_t verdict_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_cnt       = 0;
    int cycle_cnt     = 0;
    int stall_cnt     = 0;
    logic stall_req   = 1'b0;
    logic stall_done;

    // Predictor state; the fr_ fields are cleared after every last byte
    logic [2:0]  link_sel    = LT_ETHERNET;
    logic [15:0] fr_count    = '0;
    logic [15:0] fr_ether    = '0;
    logic [7:0]  fr_ver_ihl  = '0;
    logic [7:0]  fr_proto    = '0;
    logic [16:0] fr_sum      = '0;
    logic [7:0]  fr_hi       = '0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Fold one accepted byte into the running frame state; queue a verdict on the last byte.
    function automatic void advance_verdict(input in_beat_t beat);
        int pos, lhl, rel, h, cnt, ip_len;
        logic ok_link;
        out_beat_t res;
        ok_link = (link_sel <= LT_PPP);
        case (link_sel)
            LT_LOOPBACK:   lhl = 4;
            LT_ETHERNET:   lhl = 14;
            LT_SLIP, LT_PPP: lhl = 24;
            default:       lhl = 0;
        endcase
        pos = fr_count;
        if (pos < MAX_FRAME_BYTES) begin
            if (pos == 12)
                fr_ether[15:8] = beat.data_byte;
            else if (pos == 13)
                fr_ether[7:0] = beat.data_byte;
            if (ok_link && pos >= lhl) begin
                rel = pos - lhl;
                h = (rel == 0) ? beat.data_byte[3:0] * 4 : fr_ver_ihl[3:0] * 4;
                if (rel == 0)
                    fr_ver_ihl = beat.data_byte;
                if (rel == 9)
                    fr_proto = beat.data_byte;
                if (rel < h) begin
                    if (rel % 2 == 0) begin
                        fr_hi = beat.data_byte;
                    end else begin
                        fr_sum = fr_sum + {fr_hi, beat.data_byte};
                        // end-around carry
                        if (fr_sum[16])
                            fr_sum = fr_sum[15:0] + 17'd1;
                    end
                end
            end
            fr_count = fr_count + 16'd1;
        end
        if (beat.last_byte) begin
            res = '0;
            cnt = fr_count;
            if (!ok_link) begin
                res.status = ST_BAD_LINK;
            end else begin
                res.ip_start = 5'(lhl);
                if (cnt < lhl) begin
                    res.status = ST_SHORT;
                end else begin
                    h = (cnt == lhl) ? 0 : fr_ver_ihl[3:0] * 4;
                    res.header_bytes = 6'(h);
                    ip_len = cnt - lhl;
                    if (link_sel == LT_ETHERNET && fr_ether != ETHERTYPE_IPV4)
                        res.status = ST_NOT_IPV4;
                    else if (ip_len < MIN_IP_BYTES)
                        res.status = ST_SHORT;
                    else if (fr_ver_ihl[7:4] != IP_VERSION)
                        res.status = ST_VERSION;
                    else if (h < MIN_HDR_BYTES)
                        res.status = ST_HLEN;
                    else if (ip_len < h + UDP_HDR_BYTES)
                        res.status = ST_SHORT_HLEN;
                    else if (fr_sum[15:0] != 16'hFFFF)
                        res.status = ST_CHECKSUM;
                    else if (fr_proto != PROTO_UDP)
                        res.status = ST_NOT_UDP;
                    else
                        res.status = ST_OK;
                end
            end
            verdict_q.push_back(res);
            fr_count   = '0;
            fr_ether   = '0;
            fr_ver_ihl = '0;
            fr_proto   = '0;
            fr_sum     = '0;
            fr_hi      = '0;
        end
    endfunction

    // Driver: when the current beat is taken or the slot is empty, present the next byte unless a random idle is drawn.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                advance_verdict(s_data);
            if (!s_valid || s_ready) begin
                if (frame_byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_data  <= frame_byte_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || stall_req)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!stall_req)
            stall_cnt <= 0;
        else if (!stall_done)
            stall_cnt <= stall_cnt + 1;
    end
    assign stall_done = (stall_cnt >= STALL_CYCLES);

    // Monitor: compare every result beat with the oldest pending verdict.
    always @(posedge aclk) begin
        out_beat_t exp_b;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_data);
                err_cnt++;
            end else begin
                exp_b = verdict_q.pop_front();
                if (m_data.status !== exp_b.status) begin
                    $display("%0t: status exp %0d got %0d", $time, exp_b.status, m_data.status);
                    err_cnt++;
                end
                if (m_data.ip_start !== exp_b.ip_start) begin
                    $display("%0t: ip_start exp %0d got %0d", $time,
                             exp_b.ip_start, m_data.ip_start);
                    err_cnt++;
                end
                if (m_data.header_bytes !== exp_b.header_bytes) begin
                    $display("%0t: header_bytes exp %0d got %0d", $time,
                             exp_b.header_bytes, m_data.header_bytes);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d verdicts outstanding", $time, verdict_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Hold until all bytes are sent and all verdicts are back, then let the pipe drain.
    task automatic wait_quiet();
        while (frame_byte_q.size() != 0 || s_valid || verdict_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_link(input logic [2:0] lt);
        wait_quiet();
        cfg_data  <= lt;
        cfg_valid <= 1'b1;
        do
            @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        link_sel = lt;
    endtask

    task automatic queue_run(input logic [7:0] value, input int n, input logic close);
        for (int i = 0; i < n; i++)
            frame_byte_q.push_back('{data_byte: value, last_byte: close && (i == n - 1)});
    endtask

    // Build one frame for the current link type; ip_bytes > 0 forces the IP length.
    task automatic queue_frame(input frame_kind_e kind, input int ip_bytes = 0);
        logic [7:0] fb[$];
        logic [7:0] iph[60];
        logic [16:0] acc;
        int lhl, ihl, hdr, ip_len, total, idx;
        case (link_sel)
            LT_LOOPBACK:   lhl = 4;
            LT_ETHERNET:   lhl = 14;
            LT_SLIP, LT_PPP: lhl = 24;
            default:       lhl = 0;
        endcase
        if (kind == FK_NOISE) begin
            total = $urandom_range(1, 90);
            repeat (total) fb.push_back(8'($urandom));
        end else begin
            for (int i = 0; i < lhl; i++)
                fb.push_back(8'($urandom));
            if (link_sel == LT_ETHERNET) begin
                fb[12] = ETHERTYPE_IPV4[15:8];
                fb[13] = ETHERTYPE_IPV4[7:0];
                if (kind == FK_ETHERTYPE)
                    fb[12 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            end
            case (kind)
                FK_HLEN:       ihl = $urandom_range(0, 4);
                FK_SHORT_HLEN: ihl = $urandom_range(8, 15);
                default:       ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
            endcase
            hdr = ihl * 4;
            foreach (iph[i])
                iph[i] = 8'($urandom);
            iph[0] = {IP_VERSION, 4'(ihl)};
            if (kind == FK_VERSION)
                iph[0][7:4] = IP_VERSION ^ 4'($urandom_range(1, 15));
            iph[9] = PROTO_UDP;
            if (kind == FK_NOT_UDP)
                iph[9] = PROTO_UDP ^ 8'($urandom_range(1, 255));
            iph[10] = '0;
            iph[11] = '0;
            acc = '0;
            for (int i = 0; i + 1 < hdr; i += 2) begin
                acc = acc + {iph[i], iph[i+1]};
                if (acc[16])
                    acc = acc[15:0] + 17'd1;
            end
            {iph[10], iph[11]} = ~acc[15:0];
            if (kind == FK_BAD_CSUM) begin
                idx = $urandom_range(10, hdr - 1);
                iph[idx] ^= 8'(1 << $urandom_range(0, 7));
            end
            case (kind)
                FK_HLEN:       ip_len = $urandom_range(28, 48);
                FK_SHORT_HLEN: ip_len = $urandom_range(28, hdr + 7);
                default:       ip_len = hdr + $urandom_range(8, 20);
            endcase
            if (ip_bytes > 0)
                ip_len = ip_bytes;
            total = lhl + ip_len;
            if (kind == FK_TRUNC)
                total = $urandom_range(1, lhl + 27);
            else if (kind == FK_LINK_ONLY)
                total = (lhl == 0) ? 1 : lhl;
            for (int i = lhl; i < total; i++) begin
                idx = i - lhl;
                fb.push_back((idx < 60) ? iph[idx] : 8'($urandom));
            end
            while (fb.size() > total)
                void'(fb.pop_back());
        end
        foreach (fb[i])
            frame_byte_q.push_back('{data_byte: fb[i], last_byte: (i == fb.size() - 1)});
    endtask

    initial begin
        logic [2:0] lt;
        frame_kind_e kind;
        send_idle_pct = 19;
        recv_idle_pct = 71;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: Ethernet from the reset value of the link register
        queue_frame(FK_GOOD);
        queue_frame(FK_ETHERTYPE);
        queue_run(8'hA5, 1, 1'b1);
        queue_frame(FK_TRUNC);
        queue_frame(FK_LINK_ONLY);
        queue_frame(FK_VERSION);
        queue_frame(FK_HLEN);
        queue_frame(FK_SHORT_HLEN);
        queue_frame(FK_BAD_CSUM);
        queue_frame(FK_NOT_UDP);
        queue_run(8'h00, 20, 1'b1);
        queue_run(8'hFF, 20, 1'b1);

        // Change the link type in the middle of a frame
        queue_run(8'h5A, 8, 1'b0);
        write_link(LT_LOOPBACK);
        queue_frame(FK_GOOD);
        queue_frame(FK_TRUNC);
        write_link(LT_SLIP);
        queue_frame(FK_GOOD);
        write_link(LT_PPP);
        queue_frame(FK_GOOD);
        queue_frame(FK_LINK_ONLY);
        write_link(3'd4);
        queue_frame(FK_GOOD);
        write_link(3'd7);
        queue_frame(FK_NOISE);

        // Back-pressure: block the receiver while short frames keep coming
        write_link(LT_ETHERNET);
        stall_req <= 1'b1;
        repeat (20) queue_run(8'($urandom), 1, 1'b1);
        while (!stall_done) @(posedge aclk);
        stall_req <= 1'b0;
        wait_quiet();

        // Random frames, three idle profiles
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 71 : 0;
            recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 19 : 0;
            for (int blk = 0; blk < 2; blk++) begin
                lt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                                 : 3'($urandom_range(0, 3));
                write_link(lt);
                kind = ($urandom_range(0, 99) < 40) ? FK_GOOD
                                                    : frame_kind_e'($urandom_range(1, FK_NOISE));
                queue_frame(kind);
            end
        end
        wait_quiet();

        if (err_cnt == 0 && verdict_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ipufc_pkg.sv
sv/ipufc_hdr_check.sv
sv/ipv4_udp_frame_check.sv
tb/tb_top.sv
